// ===== rtl/exact_match_patricia_trie_assert.svh =====
// Assertion macros for the trie block.
`ifndef EXACT_MATCH_PATRICIA_TRIE_ASSERT_SVH
`define EXACT_MATCH_PATRICIA_TRIE_ASSERT_SVH
// Condition that must hold at every clock edge out of reset.
`define EMT_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Implication checked on the next clock edge.
`define EMT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`endif

// ===== rtl/emt_pkg.sv =====
package emt_pkg;
	localparam int MAX_KEYS = 256;
	localparam int POOL = 2 * MAX_KEYS;
	localparam int IDX_W = $clog2(POOL);
	localparam int FC_W = $clog2(POOL + 1);
	localparam int KC_W = $clog2(MAX_KEYS + 1);
	localparam int PAY_W = 32;
	localparam int KEY_BITS = 128;
	localparam int SPLIT_W = 8;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;

	typedef struct packed {
		logic [63:0]        key_hi;
		logic [63:0]        key_lo;
		logic [SPLIT_W-1:0] split;
		logic               leaf;
		logic [IDX_W-1:0]   left;
		logic [IDX_W-1:0]   right;
		logic [PAY_W-1:0]   pay;
	} node_t;

	typedef struct packed {
		logic [1:0]       act;
		logic             is_clear;
		logic             is_insert;
		logic [63:0]      key_hi;
		logic [63:0]      key_lo;
		logic [PAY_W-1:0] val;
	} item_t;

	// leading zeros of a nonzero 16-bit chunk
	function automatic logic [3:0] lz16(input logic [15:0] x);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) n = 4'(15 - i);
		end
		return n;
	endfunction
endpackage

// ===== rtl/emt_ram.sv =====
module emt_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/emt_front.sv =====
module emt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  emt_pkg::item_t in_item,
	output logic           q_valid,
	input  logic           q_pop,
	output emt_pkg::item_t q_item
);
	emt_pkg::item_t buf_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	emt_pkg::item_t cls;
	logic push;

	always_comb begin
		cls = in_item;
		cls.is_clear = (in_item.act == emt_pkg::ACT_CLEAR);
		cls.is_insert = (in_item.act == emt_pkg::ACT_INSERT);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== rtl/emt_back.sv =====
module emt_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  emt_pkg::item_t          q_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              out_status,
	output logic [emt_pkg::PAY_W-1:0] out_value,
	output logic [8:0]              out_keys
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_DAT   = 4'd2;
	localparam logic [3:0] S_DIF   = 4'd3;
	localparam logic [3:0] S_ACT   = 4'd4;
	localparam logic [3:0] S_POP1  = 4'd5;
	localparam logic [3:0] S_POP1W = 4'd6;
	localparam logic [3:0] S_POP2  = 4'd7;
	localparam logic [3:0] S_POP2W = 4'd8;
	localparam logic [3:0] S_WL    = 4'd9;
	localparam logic [3:0] S_WS    = 4'd10;
	localparam logic [3:0] S_WP    = 4'd11;
	localparam logic [3:0] S_PUSH1 = 4'd12;
	localparam logic [3:0] S_PUSH2 = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	localparam int NW = $bits(emt_pkg::node_t);
	localparam int IW = emt_pkg::IDX_W;
	localparam int FW = emt_pkg::FC_W;
	localparam int KW = emt_pkg::KC_W;

	logic [3:0] st_q;
	emt_pkg::item_t it_q;
	logic          tree_empty_q;
	logic [IW-1:0] root_q;
	logic [FW-1:0] fc_q, minfc_q;
	logic [KW-1:0] kc_q;
	logic [IW-1:0] node_q, par_idx_q, gp_idx_q, l_q, s_q;
	emt_pkg::node_t cur_q, par_q, gp_q;
	logic pbit_q, gpbit_q, has_p_q, has_gp_q, match_q, empty_ins_q, idf_q;
	logic [emt_pkg::SPLIT_W-1:0] d_q;
	logic [7:0] cnz_q;
	logic [3:0] clz_q [8];
	logic [1:0] res_st_q;
	logic [emt_pkg::PAY_W-1:0] res_val_q;
	logic ov_q;
	logic [1:0] ost_q;
	logic [emt_pkg::PAY_W-1:0] oval_q;
	logic [8:0] okeys_q;

	logic          n_we;
	logic [IW-1:0] n_waddr;
	emt_pkg::node_t n_wdata, n_rdata;
	logic [NW-1:0] n_rraw;
	logic          f_we;
	logic [IW-1:0] f_waddr, f_wdata, f_rdata;
	logic [FW-1:0] fcm1;
	logic [127:0]  key, xr;
	logic [emt_pkg::SPLIT_W-1:0] dc;
	logic          kb, nb, out_free;
	logic [IW-1:0] popped, sib;

	emt_ram #(.W(NW), .D(emt_pkg::POOL)) u_nodes (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(node_q), .rdata(n_rraw)
	);
	assign n_rdata = emt_pkg::node_t'(n_rraw);

	emt_ram #(.W(IW), .D(emt_pkg::POOL)) u_free (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(fcm1[IW-1:0]), .rdata(f_rdata)
	);

	assign fcm1 = fc_q - FW'(1);
	assign key = {it_q.key_hi, it_q.key_lo};
	assign xr = key ^ {n_rdata.key_hi, n_rdata.key_lo};
	assign out_free = !ov_q || out_ready;
	// stack entries below the lowest fill level since clear still hold their own index
	assign popped = idf_q ? fcm1[IW-1:0] + IW'(1) : f_rdata;
	assign sib = pbit_q ? par_q.left : par_q.right;

	always_comb begin
		dc = emt_pkg::SPLIT_W'(emt_pkg::KEY_BITS);
		for (int k = 7; k >= 0; k--) begin
			if (cnz_q[k]) dc = emt_pkg::SPLIT_W'(k * 16) + emt_pkg::SPLIT_W'(clz_q[k]);
		end
		kb = key[7'd127 - cur_q.split[6:0]];
		nb = key[7'd127 - d_q[6:0]];
	end

	always_comb begin
		n_we = 1'b0;
		n_waddr = node_q;
		n_wdata = cur_q;
		f_we = 1'b0;
		f_waddr = fc_q[IW-1:0];
		f_wdata = node_q;
		case (st_q)
			S_ACT: begin
				if (it_q.act == emt_pkg::ACT_INSERT && match_q) begin
					n_we = 1'b1;
					n_wdata.pay = it_q.val;
				end else if (it_q.act == emt_pkg::ACT_DELETE && match_q && has_p_q && has_gp_q) begin
					n_we = 1'b1;
					n_waddr = gp_idx_q;
					n_wdata = gp_q;
					if (gpbit_q) n_wdata.right = sib;
					else n_wdata.left = sib;
				end
			end
			S_WL: begin
				n_we = 1'b1;
				n_waddr = l_q;
				n_wdata.key_hi = it_q.key_hi;
				n_wdata.key_lo = it_q.key_lo;
				n_wdata.split = emt_pkg::SPLIT_W'(emt_pkg::KEY_BITS);
				n_wdata.leaf = 1'b1;
				n_wdata.pay = it_q.val;
			end
			S_WS: begin
				n_we = 1'b1;
				n_waddr = s_q;
				n_wdata.key_hi = it_q.key_hi;
				n_wdata.key_lo = it_q.key_lo;
				n_wdata.split = {1'b0, d_q[6:0]};
				n_wdata.leaf = 1'b0;
				n_wdata.pay = '0;
				n_wdata.left = nb ? node_q : l_q;
				n_wdata.right = nb ? l_q : node_q;
			end
			S_WP: begin
				n_we = has_p_q;
				n_waddr = par_idx_q;
				n_wdata = par_q;
				if (pbit_q) n_wdata.right = s_q;
				else n_wdata.left = s_q;
			end
			S_PUSH1: begin
				f_we = (fc_q < FW'(emt_pkg::POOL));
			end
			S_PUSH2: begin
				f_we = (fc_q < FW'(emt_pkg::POOL));
				f_wdata = par_idx_q;
			end
			default: begin
			end
		endcase
	end

	assign q_pop = (st_q == S_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_item;
		if (st_q == S_DAT) begin
			cur_q <= n_rdata;
			for (int k = 0; k < 8; k++) begin
				cnz_q[k] <= (xr[127-16*k -: 16] != 16'd0);
				clz_q[k] <= emt_pkg::lz16(xr[127-16*k -: 16]);
			end
		end
		if (st_q == S_POP1W) l_q <= popped;
		if (st_q == S_POP2W) s_q <= popped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			tree_empty_q <= 1'b1;
			root_q <= '0;
			fc_q <= FW'(emt_pkg::POOL);
			minfc_q <= FW'(emt_pkg::POOL);
			kc_q <= '0;
			ov_q <= 1'b0;
			node_q <= '0;
			has_p_q <= 1'b0;
			has_gp_q <= 1'b0;
		end else begin
			ov_q <= (st_q == S_DONE && out_free) || (ov_q && !out_ready);
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						res_st_q <= emt_pkg::ST_OK;
						res_val_q <= '0;
						has_p_q <= 1'b0;
						has_gp_q <= 1'b0;
						empty_ins_q <= tree_empty_q;
						node_q <= root_q;
						if (q_item.is_clear) begin
							tree_empty_q <= 1'b1;
							root_q <= '0;
							fc_q <= FW'(emt_pkg::POOL);
							minfc_q <= FW'(emt_pkg::POOL);
							kc_q <= '0;
							st_q <= S_DONE;
						end else if (tree_empty_q) begin
							if (!q_item.is_insert) begin
								res_st_q <= emt_pkg::ST_NOT_FOUND;
								st_q <= S_DONE;
							end else if (fc_q < FW'(1)) begin
								res_st_q <= emt_pkg::ST_NO_SPACE;
								st_q <= S_DONE;
							end else begin
								st_q <= S_POP1;
							end
						end else begin
							st_q <= S_RD;
						end
					end
				end
				S_RD: st_q <= S_DAT;
				S_DAT: st_q <= S_DIF;
				S_DIF: begin
					d_q <= dc;
					if (dc < cur_q.split) begin
						match_q <= 1'b0;
						st_q <= S_ACT;
					end else if (cur_q.leaf) begin
						match_q <= 1'b1;
						st_q <= S_ACT;
					end else begin
						gp_q <= par_q;
						gp_idx_q <= par_idx_q;
						gpbit_q <= pbit_q;
						has_gp_q <= has_p_q;
						par_q <= cur_q;
						par_idx_q <= node_q;
						pbit_q <= kb;
						has_p_q <= 1'b1;
						node_q <= kb ? cur_q.right : cur_q.left;
						st_q <= S_RD;
					end
				end
				S_ACT: begin
					st_q <= S_DONE;
					case (it_q.act)
						emt_pkg::ACT_LOOKUP: begin
							if (match_q) res_val_q <= cur_q.pay;
							else res_st_q <= emt_pkg::ST_NOT_FOUND;
						end
						emt_pkg::ACT_INSERT: begin
							if (!match_q) begin
								if (fc_q < FW'(2)) res_st_q <= emt_pkg::ST_NO_SPACE;
								else st_q <= S_POP1;
							end
						end
						default: begin
							if (!match_q) begin
								res_st_q <= emt_pkg::ST_NOT_FOUND;
							end else begin
								if (kc_q != '0) kc_q <= kc_q - KW'(1);
								if (!has_p_q) begin
									tree_empty_q <= 1'b1;
									root_q <= '0;
								end else if (!has_gp_q) begin
									root_q <= sib;
								end
								st_q <= S_PUSH1;
							end
						end
					endcase
				end
				S_POP1, S_POP2: begin
					fc_q <= fcm1;
					idf_q <= (fcm1 < minfc_q);
					if (fcm1 < minfc_q) minfc_q <= fcm1;
					st_q <= (st_q == S_POP1) ? S_POP1W : S_POP2W;
				end
				S_POP1W: st_q <= empty_ins_q ? S_WL : S_POP2;
				S_POP2W: st_q <= S_WL;
				S_WL: begin
					if (empty_ins_q) begin
						tree_empty_q <= 1'b0;
						root_q <= l_q;
						kc_q <= kc_q + KW'(1);
						st_q <= S_DONE;
					end else begin
						st_q <= S_WS;
					end
				end
				S_WS: st_q <= S_WP;
				S_WP: begin
					if (!has_p_q) root_q <= s_q;
					kc_q <= kc_q + KW'(1);
					st_q <= S_DONE;
				end
				S_PUSH1, S_PUSH2: begin
					if (fc_q < FW'(emt_pkg::POOL)) fc_q <= fc_q + FW'(1);
					st_q <= (st_q == S_PUSH1 && has_p_q) ? S_PUSH2 : S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						ost_q <= res_st_q;
						oval_q <= res_val_q;
						okeys_q <= 9'(kc_q);
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_status = ost_q;
	assign out_value = oval_q;
	assign out_keys = okeys_q;

`include "exact_match_patricia_trie_assert.svh"
	`EMT_ASSERT(a_fc_range, fc_q <= FW'(emt_pkg::POOL), "free count beyond pool")
	`EMT_ASSERT(a_min_fc, minfc_q <= fc_q, "low fill mark above free count")
	`EMT_ASSERT(a_empty_cnt, !tree_empty_q || kc_q == '0, "empty tree with keys counted")
	`EMT_ASSERT_NEXT(a_pop_ok, st_q == S_POP1 || st_q == S_POP2, fc_q < minfc_q + FW'(1) || !idf_q, "stack pop mark slip")
endmodule

// ===== rtl/exact_match_patricia_trie.sv =====
// Clear, and lookup or delete on an empty table, go straight to the result; the first insert
// places one leaf (POP1, POP1W, WL); otherwise the trie is walked, then a new key is placed
// (POP1 to WP) or one or two nodes are freed on delete (PUSH1, PUSH2); a stalled result adds its wait.
// One item at a time; the walk reads each node through the RD, DAT and DIF states.
// Up to two items queue in front while one is walked; results wait in an output register.
// Reset (arst_n low, asynchronous): table empty, all nodes free; no clearing pass.
module exact_match_patricia_trie (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // key_high[63:0], key_low[127:64], value_in[159:128]
	input  logic [1:0]   s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // payload[31:0], stored_keys[40:32], zero pad
	output logic [1:0]   m_tuser   // status
);
	emt_pkg::item_t in_item, q_item;
	logic q_valid, q_pop;
	logic [emt_pkg::PAY_W-1:0] value;
	logic [8:0] keys;

	always_comb begin
		in_item.act = s_tuser;
		in_item.is_clear = 1'b0;
		in_item.is_insert = 1'b0;
		in_item.key_hi = s_tdata[63:0];
		in_item.key_lo = s_tdata[127:64];
		in_item.val = s_tdata[128 +: emt_pkg::PAY_W];
	end

	emt_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	emt_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_status(m_tuser), .out_value(value), .out_keys(keys)
	);

	assign m_tdata = {7'd0, keys, value};
endmodule

// ===== sim/trie_checker.sv =====
`timescale 1ns / 1ps
module trie_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [159:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           fail_count,
	output int           pending
);
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [8:0]  keys;
	} answer_t;

	answer_t answer_q[$];

	// shadow trie
	logic          t_empty;
	int unsigned   t_root;
	logic [63:0]   n_hi[emt_pkg::POOL];
	logic [63:0]   n_lo[emt_pkg::POOL];
	int unsigned   n_split[emt_pkg::POOL];
	logic          n_leaf[emt_pkg::POOL];
	int unsigned   n_left[emt_pkg::POOL];
	int unsigned   n_right[emt_pkg::POOL];
	logic [31:0]   n_pay[emt_pkg::POOL];
	int unsigned   free_stk[emt_pkg::POOL];
	int unsigned   free_cnt;
	int unsigned   key_cnt;

	function automatic void trie_reset();
		t_empty = 1'b1;
		t_root = 0;
		for (int i = 0; i < emt_pkg::POOL; i++) begin
			free_stk[i] = i;
			n_hi[i] = '0; n_lo[i] = '0; n_split[i] = 0; n_leaf[i] = 0;
			n_left[i] = 0; n_right[i] = 0; n_pay[i] = '0;
		end
		free_cnt = emt_pkg::POOL;
		key_cnt = 0;
	endfunction

	function automatic int unsigned first_diff(logic [127:0] k, int unsigned n);
		logic [127:0] x;
		x = k ^ {n_hi[n], n_lo[n]};
		for (int i = 0; i < 128; i++)
			if (x[127-i]) return i;
		return emt_pkg::KEY_BITS;
	endfunction

	function automatic logic bit_at(logic [127:0] k, int unsigned p);
		return k[127 - (p % 128)];
	endfunction

	function automatic int unsigned pop_node();
		free_cnt--;
		return free_stk[free_cnt] % emt_pkg::POOL;
	endfunction

	function automatic void push_node(int unsigned n);
		if (free_cnt < emt_pkg::POOL) begin
			free_stk[free_cnt] = n;
			free_cnt++;
		end
	endfunction

	function automatic void link(int unsigned n, logic b, int unsigned c);
		if (b) n_right[n] = c;
		else n_left[n] = c;
	endfunction

	function automatic answer_t trie_apply(logic [1:0] act, logic [127:0] k, logic [31:0] v);
		answer_t r;
		int unsigned node, par, gp, d, l, s;
		logic pb, gpb, b, nb, has_p, has_gp, hit;
		r = '0;
		r.status = emt_pkg::ST_OK;
		if (act == emt_pkg::ACT_CLEAR) begin
			trie_reset();
		end else if (t_empty) begin
			if (act != emt_pkg::ACT_INSERT) r.status = emt_pkg::ST_NOT_FOUND;
			else if (free_cnt < 1) r.status = emt_pkg::ST_NO_SPACE;
			else begin
				l = pop_node();
				{n_hi[l], n_lo[l]} = k;
				n_split[l] = emt_pkg::KEY_BITS; n_leaf[l] = 1'b1; n_pay[l] = v;
				t_root = l; t_empty = 1'b0; key_cnt++;
			end
		end else begin
			node = t_root % emt_pkg::POOL; par = 0; gp = 0; pb = 0; gpb = 0; d = 0;
			has_p = 0; has_gp = 0; hit = 0;
			for (int st = 0; st <= emt_pkg::KEY_BITS; st++) begin
				d = first_diff(k, node);
				if (d < n_split[node]) break;
				if (n_leaf[node]) begin
					hit = 1;
					break;
				end
				b = bit_at(k, n_split[node]);
				gp = par; gpb = pb; has_gp = has_p;
				par = node; pb = b; has_p = 1;
				node = (b ? n_right[node] : n_left[node]) % emt_pkg::POOL;
			end
			if (act == emt_pkg::ACT_LOOKUP) begin
				if (hit) r.value = n_pay[node];
				else r.status = emt_pkg::ST_NOT_FOUND;
			end else if (act == emt_pkg::ACT_INSERT) begin
				if (hit) n_pay[node] = v;
				else if (free_cnt < 2) r.status = emt_pkg::ST_NO_SPACE;
				else begin
					l = pop_node();
					s = pop_node();
					nb = bit_at(k, d);
					{n_hi[l], n_lo[l]} = k;
					n_split[l] = emt_pkg::KEY_BITS; n_leaf[l] = 1'b1; n_pay[l] = v;
					{n_hi[s], n_lo[s]} = k;
					n_split[s] = d % 128; n_leaf[s] = 1'b0; n_pay[s] = '0;
					link(s, nb, l);
					link(s, !nb, node);
					if (has_p) link(par, pb, s);
					else t_root = s;
					key_cnt++;
				end
			end else begin
				if (!hit) r.status = emt_pkg::ST_NOT_FOUND;
				else if (!has_p) begin
					push_node(node);
					t_empty = 1'b1; t_root = 0;
					if (key_cnt > 0) key_cnt--;
				end else begin
					l = (pb ? n_left[par] : n_right[par]) % emt_pkg::POOL;
					if (has_gp) link(gp, gpb, l);
					else t_root = l;
					push_node(node);
					push_node(par);
					if (key_cnt > 0) key_cnt--;
				end
			end
		end
		r.keys = key_cnt[8:0];
		return r;
	endfunction

	assign pending = answer_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		answer_t want, got;
		if (!arst_n) begin
			trie_reset();
			answer_q.delete();
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				answer_q.push_back(trie_apply(s_tuser,
					{s_tdata[63:0], s_tdata[127:64]}, s_tdata[159:128]));
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.value = m_tdata[31:0];
				got.keys = m_tdata[40:32];
				if (answer_q.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = answer_q.pop_front();
					if (want != got || m_tdata[47:41] != '0) begin
						$display("%0t: mismatch expected st=%0d val=%h keys=%0d, actual st=%0d val=%h keys=%0d",
							$time, want.status, want.value, want.keys,
							got.status, got.value, got.keys);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== sim/tb_exact_match_patricia_trie.sv =====
`timescale 1ns / 1ps
module tb_exact_match_patricia_trie;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           fail_count;
	int           pending;
	int           idle_pct;
	int           quiet;
	logic [127:0] key_pool[64];

	exact_match_patricia_trie u_dut (.*);

	trie_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n) quiet <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("tb_exact_match_patricia_trie: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic send(logic [1:0] act, logic [127:0] k, logic [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {v, k[63:0], k[127:64]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [127:0] rand_key();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [127:0] pick_key();
		logic [127:0] k;
		case ($urandom_range(9))
			0: k = rand_key();
			1: k = key_pool[$urandom_range(63)] ^ (128'd1 << $urandom_range(127));
			default: k = key_pool[$urandom_range(63)];
		endcase
		return k;
	endfunction

	initial begin
		logic [1:0] act;
		int r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = emt_pkg::ACT_LOOKUP;
		idle_pct = 19;
		for (int i = 0; i < 64; i++) key_pool[i] = rand_key();
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 128'd1;
		key_pool[3] = {1'b1, 127'd0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-tree cases, extremes, update, deletes, clear
		send(emt_pkg::ACT_LOOKUP, '0, '0);
		send(emt_pkg::ACT_DELETE, '1, '0);
		send(emt_pkg::ACT_INSERT, '0, 32'hFFFF_FFFF);
		send(emt_pkg::ACT_LOOKUP, '0, '0);
		send(emt_pkg::ACT_INSERT, '0, 32'h1234_5678);
		send(emt_pkg::ACT_LOOKUP, '0, '1);
		send(emt_pkg::ACT_INSERT, '1, '0);
		send(emt_pkg::ACT_INSERT, 128'd1, 32'hA5A5_A5A5);
		send(emt_pkg::ACT_INSERT, {1'b1, 127'd0}, 32'h5A5A_5A5A);
		send(emt_pkg::ACT_LOOKUP, 128'd1, '0);
		send(emt_pkg::ACT_LOOKUP, 128'd2, '0);
		send(emt_pkg::ACT_DELETE, 128'd2, '0);
		send(emt_pkg::ACT_DELETE, 128'd1, '0);
		send(emt_pkg::ACT_LOOKUP, 128'd1, '0);
		send(emt_pkg::ACT_DELETE, '0, '0);
		send(emt_pkg::ACT_DELETE, '1, '0);
		send(emt_pkg::ACT_DELETE, {1'b1, 127'd0}, '0);
		send(emt_pkg::ACT_LOOKUP, '1, '0);
		send(emt_pkg::ACT_INSERT, '1, 32'd7);
		send(emt_pkg::ACT_CLEAR, '1, '1);
		send(emt_pkg::ACT_LOOKUP, '1, '0);

		// fill the pool to force no-space
		for (int i = 0; i < 260; i++) send(emt_pkg::ACT_INSERT, rand_key(), $urandom);
		send(emt_pkg::ACT_INSERT, key_pool[5], $urandom);
		send(emt_pkg::ACT_CLEAR, '0, '0);
		s_tvalid <= 1'b0;

		// hold off until everything has drained
		while (pending != 0) @(posedge clk);

		for (int i = 0; i < 1420; i++) begin
			idle_pct = (i >= 500 && i < 800) ? 0 : 19;
			r = $urandom_range(99);
			if (r < 40) act = emt_pkg::ACT_INSERT;
			else if (r < 70) act = emt_pkg::ACT_LOOKUP;
			else if (r < 99) act = emt_pkg::ACT_DELETE;
			else act = emt_pkg::ACT_CLEAR;
			send(act, pick_key(), $urandom);
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb_exact_match_patricia_trie: clean");
		else
			$display("tb_exact_match_patricia_trie: errors");
		$finish;
	end
endmodule
